// ===== rtl/scra_pkg.sv =====
`default_nettype none

package scra_pkg;

  localparam int WORD_W  = 32;
  localparam int WORD_SH = 5;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_SLOT     = 2'd1;
  localparam logic [1:0] ST_NO_REGION   = 2'd2;
  localparam logic [1:0] ST_BAD_RELEASE = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [31:0] request_size;
    logic [3:0]  slot_id;
  } scra_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  granted_slot;
    logic [31:0] base_address;
    logic [3:0]  granted_order;
  } scra_res_t;

endpackage

`default_nettype wire

// ===== rtl/slot_chunk_region_allocator_unit.sv =====
// Channel   Ports                                  Handshake
// request   start, busy, in_req                    taken when start && !busy
// result    out_valid, out_res                     one-cycle strobe, no back-pressure
// config    cfg_valid, cfg_ready, cfg_data         written when cfg_valid && cfg_ready
//
// Allocate: find the order, read and check each row examined, then write the run's rows.
// Release: a run up to one row is read, cleared and written back; longer runs are zeroed.
// The chunk bitmap sits in a 32-bit-wide memory with one port; the row scan sets the time.
// Synchronous active-low reset; the bitmap rows are cleared by per-row valid bits.
// busy stays high until the result strobe; the result side cannot stall.
`default_nettype none

module slot_chunk_region_allocator_unit #(
  parameter int CHUNK_COUNT = 256,
  parameter int CHUNK_SHIFT = 21,
  parameter int SLOT_COUNT  = 16,
  parameter int FIRST_SLOT  = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  scra_pkg::scra_req_t in_req,
  output logic                out_valid,
  output scra_pkg::scra_res_t out_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import scra_pkg::*;

  localparam int ROWS      = (CHUNK_COUNT + WORD_W - 1) / WORD_W;
  localparam int FULL_ROWS = CHUNK_COUNT / WORD_W;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RC_W      = $clog2(ROWS + 1);
  localparam int POS_W     = $clog2(CHUNK_COUNT);
  localparam int ORD_FAIL  = $clog2(CHUNK_COUNT + 1);
  localparam int ORD_W     = $clog2(ORD_FAIL + 1);
  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int CNT_W     = 33 - CHUNK_SHIFT;
  localparam logic [32:0] ROUND_ADD = 33'((64'd1 << CHUNK_SHIFT) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE, S_ORD, S_REL, S_RD, S_CHK, S_FILL, S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  scra_res_t           out_res_r, out_res_nxt;
  logic [31:0]         pool_base_r, pool_base_nxt;
  logic [SLOT_COUNT-1:0] slot_busy_r, slot_busy_nxt;
  logic [ROWS-1:0]     map_vld_r, map_vld_nxt;

  logic                mode_r, mode_nxt;
  logic [3:0]          gslot_r, gslot_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [CNT_W-1:0]    chunks_r, chunks_nxt;
  logic [ORD_W-1:0]    ord_r, ord_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [RC_W-1:0]     c_r, c_nxt;
  logic [RC_W-1:0]     rs_r, rs_nxt;
  logic [WORD_W-1:0]   fill_r, fill_nxt;

  logic [WORD_W-1:0]   map_mem [ROWS];
  logic [WORD_W-1:0]   map_q;
  logic                vld_q;
  logic [POS_W-1:0]    spos_mem [SLOT_COUNT];
  logic [ORD_W-1:0]    sord_mem [SLOT_COUNT];
  logic [POS_W-1:0]    spos_q;
  logic [ORD_W-1:0]    sord_q;

  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;
  logic [SLOT_W-1:0]   sid_idx;
  logic                sid_ok;
  logic [ROW_W-1:0]    c_idx;
  logic                map_we;
  logic                slot_we;
  logic                is_large;
  logic [RC_W-1:0]     run_rows;
  logic [RC_W-1:0]     run_last;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign sid_idx  = SLOT_W'(in_req.slot_id);
  assign sid_ok   = 32'(in_req.slot_id) < SLOT_COUNT;
  assign c_idx    = c_r[ROW_W-1:0];
  assign is_large = ord_r > ORD_W'(WORD_SH);
  assign run_rows = is_large ? (RC_W'(1) << (ord_r - ORD_W'(WORD_SH))) : RC_W'(1);
  assign run_last = RC_W'(rs_r + run_rows - RC_W'(1));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= FIRST_SLOT; i--) begin
      if (!slot_busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    logic [WORD_W-1:0] word;
    logic [5:0]        n_small;
    logic [WORD_W-1:0] mask_n;
    logic [4:0]        align_m;
    int                rem;
    logic              cand_hit;
    logic [4:0]        cand_bit;
    logic [31:0]       lin;

    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    pool_base_nxt = pool_base_r;
    slot_busy_nxt = slot_busy_r;
    map_vld_nxt   = map_vld_r;
    mode_nxt      = mode_r;
    gslot_nxt     = gslot_r;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    chunks_nxt    = chunks_r;
    ord_nxt       = ord_r;
    pos_nxt       = pos_r;
    c_nxt         = c_r;
    rs_nxt        = rs_r;
    fill_nxt      = fill_r;
    map_we        = 1'b0;
    slot_we       = 1'b0;

    word     = vld_q ? map_q : '0;
    n_small  = 6'd1 << ord_r[2:0];
    mask_n   = 32'((33'd1 << n_small) - 33'd1);
    align_m  = 5'(n_small - 6'd1);
    rem      = CHUNK_COUNT - int'(c_r) * WORD_W;
    cand_hit = 1'b0;
    cand_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (((5'(b) & align_m) == 5'd0) && ((word & (mask_n << b)) == '0) &&
          (b + int'(n_small) <= rem)) begin
        cand_hit = 1'b1;
        cand_bit = 5'(b);
      end
    end
    lin = 32'(pos_r);

    if (cfg_valid && cfg_ready) begin
      pool_base_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = in_req.mode;
          gslot_nxt = '0;
          if (in_req.mode == MODE_RELEASE) begin
            gslot_nxt = in_req.slot_id;
            slot_nxt  = sid_idx;
            if (sid_ok && slot_busy_r[sid_idx]) begin
              status_nxt = ST_OK;
              state_nxt  = S_REL;
            end else begin
              status_nxt = ST_BAD_RELEASE;
              state_nxt  = S_FIN;
            end
          end else if (!free_found) begin
            status_nxt = ST_NO_SLOT;
            state_nxt  = S_FIN;
          end else begin
            slot_nxt   = free_idx;
            gslot_nxt  = 4'(free_idx);
            chunks_nxt = CNT_W'(({1'b0, in_req.request_size} + ROUND_ADD) >> CHUNK_SHIFT);
            ord_nxt    = '0;
            status_nxt = ST_OK;
            state_nxt  = S_ORD;
          end
        end
      end
      S_ORD: begin
        if (ord_r == ORD_W'(ORD_FAIL)) begin
          status_nxt = ST_NO_REGION;
          state_nxt  = S_FIN;
        end else if ((chunks_r != '0) && (((chunks_r - CNT_W'(1)) >> ord_r) != '0)) begin
          ord_nxt = ORD_W'(ord_r + ORD_W'(1));
        end else begin
          rs_nxt    = '0;
          c_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_REL: begin
        ord_nxt = sord_q;
        pos_nxt = spos_q;
        c_nxt   = RC_W'(32'(spos_q) >> WORD_SH);
        rs_nxt  = RC_W'(32'(spos_q) >> WORD_SH);
        if (sord_q > ORD_W'(WORD_SH)) begin
          fill_nxt  = '0;
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (mode_r == MODE_RELEASE) begin
          fill_nxt  = word & ~(mask_n << lin[4:0]);
          state_nxt = S_FILL;
        end else if (is_large) begin
          if (word != '0) begin
            rs_nxt = RC_W'(rs_r + run_rows);
            c_nxt  = RC_W'(rs_r + run_rows);
            if (int'(rs_r) + 2 * int'(run_rows) > FULL_ROWS) begin
              status_nxt = ST_NO_REGION;
              state_nxt  = S_FIN;
            end else begin
              state_nxt = S_RD;
            end
          end else if (c_r == run_last) begin
            pos_nxt   = POS_W'(32'(rs_r) << WORD_SH);
            fill_nxt  = '1;
            c_nxt     = rs_r;
            state_nxt = S_FILL;
          end else begin
            c_nxt     = RC_W'(c_r + RC_W'(1));
            state_nxt = S_RD;
          end
        end else begin
          if (cand_hit) begin
            pos_nxt   = POS_W'((32'(c_r) << WORD_SH) | 32'(cand_bit));
            fill_nxt  = word | (mask_n << cand_bit);
            rs_nxt    = c_r;
            state_nxt = S_FILL;
          end else if (c_r == RC_W'(ROWS - 1)) begin
            status_nxt = ST_NO_REGION;
            state_nxt  = S_FIN;
          end else begin
            c_nxt     = RC_W'(c_r + RC_W'(1));
            rs_nxt    = RC_W'(c_r + RC_W'(1));
            state_nxt = S_RD;
          end
        end
      end
      S_FILL: begin
        map_we             = 1'b1;
        map_vld_nxt[c_idx] = 1'b1;
        if (c_r == run_last) begin
          state_nxt = S_FIN;
        end else begin
          c_nxt = RC_W'(c_r + RC_W'(1));
        end
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        out_res_nxt.status        = status_r;
        out_res_nxt.granted_slot  = '0;
        out_res_nxt.base_address  = '0;
        out_res_nxt.granted_order = '0;
        if (status_r == ST_OK) begin
          out_res_nxt.granted_slot  = gslot_r;
          out_res_nxt.base_address  = pool_base_r + (32'(pos_r) << CHUNK_SHIFT);
          out_res_nxt.granted_order = 4'(ord_r);
          if (mode_r == MODE_ALLOC) begin
            slot_busy_nxt[slot_r] = 1'b1;
            slot_we               = 1'b1;
          end else begin
            slot_busy_nxt[slot_r] = 1'b0;
          end
        end else if (status_r == ST_BAD_RELEASE) begin
          out_res_nxt.granted_slot = gslot_r;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_res_r   <= '0;
      pool_base_r <= '0;
      slot_busy_r <= '0;
      map_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_res_r   <= out_res_nxt;
      pool_base_r <= pool_base_nxt;
      slot_busy_r <= slot_busy_nxt;
      map_vld_r   <= map_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    gslot_r  <= gslot_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    chunks_r <= chunks_nxt;
    ord_r    <= ord_nxt;
    pos_r    <= pos_nxt;
    c_r      <= c_nxt;
    rs_r     <= rs_nxt;
    fill_r   <= fill_nxt;
    vld_q    <= map_vld_r[c_idx];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[c_idx] <= fill_r;
    end
    map_q <= map_mem[c_idx];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      spos_mem[slot_r] <= pos_r;
      sord_mem[slot_r] <= ord_r;
    end
    spos_q <= spos_mem[sid_idx];
    sord_q <= sord_mem[sid_idx];
  end

endmodule

`default_nettype wire

// ===== rtl/scra_checker.sv =====
`default_nettype none

module scra_props (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input scra_pkg::scra_res_t out_res
);
  import scra_pkg::*;

  a_take_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken without going busy");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_busy_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.status != ST_OK) |->
      (out_res.base_address == '0) && (out_res.granted_order == '0))
    else $error("failed request carries a region");

endmodule

bind slot_chunk_region_allocator_unit scra_props u_scra_props (.*);

`default_nettype wire
